// ----- sv/tcq_pkg.sv -----
// Shared types and codes for the two-class promotion queue.
`default_nettype none

package tcq_pkg;

   localparam int ID_W  = 14;
   localparam int TAG_W = 16;

   typedef enum logic [1:0] {
      FUNC_APPEND = 2'd0,
      FUNC_URGENT = 2'd1,
      FUNC_GRANT  = 2'd2,
      FUNC_DRAIN  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      KIND_GRANT          = 3'd0,
      KIND_GRANT_EMPTY    = 3'd1,
      KIND_DRAIN          = 3'd2,
      KIND_DRAIN_EMPTY    = 3'd3,
      KIND_URGENT_IGNORED = 3'd4,
      KIND_FULL           = 3'd5
   } kind_type;

   typedef struct packed {
      func_type           func;
      logic [ID_W-1:0]    flight_id;
      logic [TAG_W-1:0]   origin_tag;
   } req_type;

   typedef struct packed {
      kind_type           kind;
      logic [ID_W-1:0]    out_id;
      logic [TAG_W-1:0]   out_origin;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [TAG_W-1:0]   origin;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic     append;     // write request at tail, grow queue
      logic     load_key;   // latch id searched by urgent op
      logic     idx_clr;
      logic     idx_inc;
      logic     idx_dec;
      logic     rd_en;      // read logical idx (or idx-1 with rd_prev)
      logic     rd_prev;
      logic     hold_load;  // keep the matched entry
      logic     wr_shift;   // write read data at logical idx
      logic     wr_hold;    // write kept entry at urgent boundary, grow section
      logic     pop;        // drop head
      logic     clear;      // empty queue
      logic     emit;
      kind_type emit_kind;
      logic     emit_data;  // take id/origin from read data, else zeros
      logic     emit_last;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic empty;
      logic full;
      logic idx_end;      // idx == occupancy
      logic idx_last;     // idx == occupancy - 1
      logic idx_urgent;   // idx inside urgent section
      logic idx_at_ucnt;  // idx on urgent boundary
      logic hit;          // read id matches key
      logic out_free;     // output register can take a transaction
   } ctl_sts_type;

endpackage

`default_nettype wire

// ----- sv/tcq_ctrl.sv -----
// Sequencer for the promotion queue: decodes ops and steps the datapath.
`default_nettype none

module tcq_ctrl
   import tcq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire func_type    req_func,
   output logic             req_stall,
   input  wire ctl_sts_type sts,
   output ctl_cmd_type      cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_GRANT_RD,
      ST_GRANT_OUT,
      ST_DRAIN_RD,
      ST_DRAIN_OUT,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_APPEND: begin
                     if (sts.full) begin
                        kind_in  = KIND_FULL;
                        state_in = ST_EMIT;
                     end else begin
                        cmd.append = 1'b1;
                     end
                  end
                  FUNC_URGENT: begin
                     cmd.load_key = 1'b1;
                     cmd.idx_clr  = 1'b1;
                     state_in     = ST_SCAN_RD;
                  end
                  FUNC_GRANT: begin
                     if (sts.empty) begin
                        kind_in  = KIND_GRANT_EMPTY;
                        state_in = ST_EMIT;
                     end else begin
                        cmd.idx_clr = 1'b1;
                        state_in    = ST_GRANT_RD;
                     end
                  end
                  FUNC_DRAIN: begin
                     if (sts.empty) begin
                        kind_in  = KIND_DRAIN_EMPTY;
                        state_in = ST_EMIT;
                     end else begin
                        cmd.idx_clr = 1'b1;
                        state_in    = ST_DRAIN_RD;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SCAN_RD: begin
            if (sts.idx_end) begin
               kind_in  = KIND_URGENT_IGNORED;
               state_in = ST_EMIT;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (sts.hit) begin
               if (sts.idx_urgent) begin
                  kind_in  = KIND_URGENT_IGNORED;
                  state_in = ST_EMIT;
               end else begin
                  cmd.hold_load = 1'b1;
                  state_in      = ST_SHIFT_RD;
               end
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_SCAN_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (sts.idx_at_ucnt) begin
               cmd.wr_hold = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_prev = 1'b1;
               state_in    = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.idx_dec  = 1'b1;
            state_in     = ST_SHIFT_RD;
         end
         ST_GRANT_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_GRANT_OUT;
         end
         ST_GRANT_OUT: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_GRANT;
               cmd.emit_data = 1'b1;
               cmd.emit_last = 1'b1;
               cmd.pop       = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_DRAIN_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_DRAIN_OUT;
         end
         ST_DRAIN_OUT: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_DRAIN;
               cmd.emit_data = 1'b1;
               cmd.emit_last = sts.idx_last;
               if (sts.idx_last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_DRAIN_RD;
               end
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = kind_ff;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= KIND_GRANT;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/tcq_dpath.sv -----
// Queue storage, pointers, search compare and output register.
`default_nettype none

module tcq_dpath
   import tcq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire req_type     req_data,
   input  wire ctl_cmd_type cmd,
   output ctl_sts_type      sts,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

   // circular buffer, head at logical index 0
   entry_type entry_mem [DEPTH];

   logic [AW-1:0]   head_ff;
   logic [CW-1:0]   occ_ff;
   logic [CW-1:0]   ucnt_ff;
   logic [CW-1:0]   idx_ff;
   logic [ID_W-1:0] key_ff;
   entry_type       hold_ff;
   entry_type       rd_data_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_data_ff;

   logic [CW-1:0]   rd_lidx;
   logic [AW-1:0]   rd_addr;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   entry_type       wr_data;

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                          input logic [CW-1:0] lidx);
      logic [AW:0] sum;
      sum = {1'b0, base} + (AW + 1)'(lidx);
      if (sum >= DEPTH_A) begin
         sum = sum - DEPTH_A;
      end
      return sum[AW-1:0];
   endfunction

   assign rd_lidx = cmd.rd_prev ? (idx_ff - CW'(1)) : idx_ff;
   assign rd_addr = phys(head_ff, rd_lidx);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = phys(head_ff, occ_ff);
      wr_data = '{id: req_data.flight_id, origin: req_data.origin_tag};
      if (cmd.append) begin
         wr_en = 1'b1;
      end else if (cmd.wr_shift) begin
         wr_en   = 1'b1;
         wr_addr = phys(head_ff, idx_ff);
         wr_data = rd_data_ff;
      end else if (cmd.wr_hold) begin
         wr_en   = 1'b1;
         wr_addr = phys(head_ff, ucnt_ff);
         wr_data = hold_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_key) begin
         key_ff <= req_data.flight_id;
      end
      if (cmd.hold_load) begin
         hold_ff <= rd_data_ff;
      end
      if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + CW'(1);
      end else if (cmd.idx_dec) begin
         idx_ff <= idx_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         occ_ff  <= '0;
         ucnt_ff <= '0;
      end else if (cmd.clear) begin
         head_ff <= '0;
         occ_ff  <= '0;
         ucnt_ff <= '0;
      end else if (cmd.pop) begin
         head_ff <= (head_ff == LAST_A) ? '0 : head_ff + AW'(1);
         occ_ff  <= occ_ff - CW'(1);
         if (ucnt_ff != '0) begin
            ucnt_ff <= ucnt_ff - CW'(1);
         end
      end else if (cmd.append) begin
         occ_ff <= occ_ff + CW'(1);
      end else if (cmd.wr_hold) begin
         ucnt_ff <= ucnt_ff + CW'(1);
      end
   end

   // output register: a finished transaction waits here
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff.kind       <= cmd.emit_kind;
         rsp_data_ff.out_id     <= cmd.emit_data ? rd_data_ff.id : '0;
         rsp_data_ff.out_origin <= cmd.emit_data ? rd_data_ff.origin : '0;
         rsp_data_ff.last       <= cmd.emit_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign sts.empty       = (occ_ff == '0);
   assign sts.full        = (occ_ff == DEPTH_C);
   assign sts.idx_end     = (idx_ff == occ_ff);
   assign sts.idx_last    = ((idx_ff + CW'(1)) == occ_ff);
   assign sts.idx_urgent  = (idx_ff < ucnt_ff);
   assign sts.idx_at_ucnt = (idx_ff == ucnt_ff);
   assign sts.hit         = (rd_data_ff.id == key_ff);
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= DEPTH_C)
      else $error("occupancy above depth");

   a_ucnt_bound: assert property (@(posedge clock) disable iff (reset)
      ucnt_ff <= occ_ff)
      else $error("urgent section larger than queue");

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwrites a waiting transaction");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd.append |=> (occ_ff == $past(occ_ff) + CW'(1)) && (occ_ff != '0))
      else $error("append lost or wrapped occupancy");

endmodule

`default_nettype wire

// ----- sv/two_class_queue_with_promotion.sv -----
// Top level of the two-class request queue with urgent promotion.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------
//  req     | in        | req_valid / req_stall  | req_data  (func, id, origin)
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_data  (kind, id, origin, last)
//
// Transactions are stepped through the single-port entry memory and its
// registered read, one step per read or write: append writes the tail; grant
// reads and pops the head; drain reads each entry in turn; urgent scans for the
// id, shifts the normal entries ahead of it back and puts it at the urgent boundary.
// Reset (synchronous, active high) empties the queue and the output register.
// A result waits in the output register while rsp_stall is high; the next
// request is still taken, and the sequencer only waits when it must emit.
`default_nettype none

module two_class_queue_with_promotion
   import tcq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   // sequencer: one op at a time, steps through search, shift and drain
   tcq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // storage, pointers and the result register
   tcq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
